>>> rtl/slcp_pkg.sv
`timescale 1ns / 1ps
package slcp_pkg;

  localparam int LineCapacityDef = 64;
  localparam int PageBytesDef    = 16;
  localparam int PageCountDef    = 16;
  localparam int QueueDepth      = 2;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_W     = 8'h57;
  localparam logic [7:0] CHR_H     = 8'h48;
  localparam logic [7:0] CHR_L     = 8'h4C;
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_I     = 8'h49;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_F     = 8'h46;

  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_PAGE = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  localparam logic [1:0] CMD_STATUS = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] flags;
    logic       flash;
    logic [3:0] page;
  } cmd_t;

  // back part asks the front for a hex pair and frees the line store when done
  typedef struct packed {
    logic [4:0] idx;
    logic       release_line;
  } mem_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] page;
    logic [4:0] idx;
    logic [3:0] flags;
    logic       last;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
    return d;
  endfunction

endpackage

>>> rtl/slcp_front.sv
`timescale 1ns / 1ps
module slcp_front #(
  parameter int LINE_CAPACITY = 64,
  parameter int PAGE_BYTES    = 16,
  parameter int PAGE_COUNT    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        key,
  input  logic              flash_indicator,
  output logic              q_push,
  output slcp_pkg::cmd_t    q_data,
  input  logic              q_full,
  input  slcp_pkg::mem_req_t req,
  output logic [7:0]        rd_hi,
  output logic [7:0]        rd_lo
);
  import slcp_pkg::*;

  localparam int LenW     = $clog2(LINE_CAPACITY + 1);
  localparam int AddrW    = $clog2(LINE_CAPACITY);
  localparam int WLineLen = 4 + 2 * PAGE_BYTES;

  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_CR   = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;

  logic [1:0]      mode, mode_next;
  logic [LenW-1:0] len, len_next;
  logic [3:0]      flags, flags_next;
  logic            lock;
  logic [7:0]      b0, b1, b2, b3;
  logic [7:0]      mem [LINE_CAPACITY];

  logic            accept, run, wr_en;
  logic [3:0]      tbit;
  logic [7:0]      page;
  logic            page_ok, match_h, match_t, match_w, match_l;
  logic [7:0]      addr_hi, addr_lo;

  assign full   = q_full | lock;
  assign accept = push & ~full;

  always_comb begin
    unique case (b1)
      CHR_T:   tbit = 4'b0001;
      CHR_B:   tbit = 4'b0010;
      CHR_R:   tbit = 4'b0100;
      CHR_I:   tbit = 4'b1000;
      default: tbit = 4'b0000;
    endcase
  end

  assign page    = {hex_digit(b1), hex_digit(b2)};
  assign page_ok = {1'b0, page} < 9'(PAGE_COUNT);
  assign match_h = (len == LenW'(1)) && (b0 == CHR_H);
  assign match_l = (len == LenW'(1)) && (b0 == CHR_L);
  assign match_t = (len == LenW'(2)) && (b0 == CHR_T) && (tbit != 4'b0000);
  assign match_w = (8'(len) == 8'(WLineLen)) && (b0 == CHR_W) && (b3 == CHR_COLON)
                   && page_ok;

  // a line ends on LF seen in data mode or straight after CR
  assign run    = accept && (key == CHR_LF) && (mode == MODE_DATA || mode == MODE_CR);
  assign q_push = run && (match_h || match_t || match_w || match_l);

  always_comb begin
    q_data.cmd   = match_w ? CMD_WRITE : (match_l ? CMD_LOAD : CMD_STATUS);
    q_data.flags = match_t ? (flags ^ tbit) : flags;
    q_data.flash = flash_indicator;
    q_data.page  = page[3:0];
  end

  assign flags_next = (run && match_t) ? (flags ^ tbit) : flags;
  assign wr_en = accept && (mode == MODE_DATA) && (key != CHR_CR) && (key != CHR_LF)
                 && (len < LenW'(LINE_CAPACITY));

  always_comb begin
    mode_next = mode;
    len_next  = len;
    if (accept) begin
      unique case (mode)
        MODE_DATA: begin
          if (key == CHR_CR) begin
            mode_next = MODE_CR;
          end else if (key == CHR_LF) begin
            len_next = '0;
          end else begin
            len_next = len + LenW'(1);
            if (len_next >= LenW'(LINE_CAPACITY)) mode_next = MODE_WAIT;
          end
        end
        MODE_CR: begin
          if (key == CHR_LF) begin
            len_next  = '0;
            mode_next = MODE_DATA;
          end else begin
            mode_next = MODE_WAIT;
          end
        end
        default: begin
          if (key == CHR_LF) begin
            len_next  = '0;
            mode_next = MODE_DATA;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_DATA;
      len   <= '0;
      flags <= '0;
      lock  <= 1'b0;
    end else begin
      mode  <= mode_next;
      len   <= len_next;
      flags <= flags_next;
      // the store holds the page line until the back part has read it out
      if (q_push && match_w) lock <= 1'b1;
      else if (req.release_line) lock <= 1'b0;
    end
  end

  // the first few bytes are kept aside so the line can be classified at once
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (len == LenW'(0)) b0 <= key;
      if (len == LenW'(1)) b1 <= key;
      if (len == LenW'(2)) b2 <= key;
      if (len == LenW'(3)) b3 <= key;
    end
  end

  assign addr_hi = 8'd4 + {2'b00, req.idx, 1'b0};
  assign addr_lo = 8'd5 + {2'b00, req.idx, 1'b0};

  always_ff @(posedge clk) begin
    if (wr_en) mem[len[AddrW-1:0]] <= key;
    rd_hi <= mem[addr_hi[AddrW-1:0]];
    rd_lo <= mem[addr_lo[AddrW-1:0]];
  end

endmodule

>>> rtl/slcp_cmd_queue.sv
`timescale 1ns / 1ps
module slcp_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  slcp_pkg::cmd_t wr_data,
  output logic           q_full,
  input  logic           rd,
  output slcp_pkg::cmd_t rd_data,
  output logic           q_empty
);
  import slcp_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            slots [QueueDepth];
  logic [PtrW-1:0] wp, rp;
  logic [PtrW:0]   count;

  assign q_full  = (count == (PtrW + 1)'(QueueDepth));
  assign q_empty = (count == '0);
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + PtrW'(1);
      if (rd) rp <= rp + PtrW'(1);
      count <= count + (PtrW + 1)'(wr) - (PtrW + 1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_data;
  end

endmodule

>>> rtl/slcp_back.sv
`timescale 1ns / 1ps
module slcp_back #(
  parameter int PAGE_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  slcp_pkg::cmd_t      head,
  input  logic                q_empty,
  output logic                q_pop,
  output slcp_pkg::mem_req_t  req,
  input  logic [7:0]          rd_hi,
  input  logic [7:0]          rd_lo,
  input  logic                pop,
  output logic                empty,
  output slcp_pkg::result_t   res
);
  import slcp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_S    = 4'd2;
  localparam logic [3:0] ST_LET  = 4'd3;
  localparam logic [3:0] ST_CR   = 4'd4;
  localparam logic [3:0] ST_LF   = 4'd5;
  localparam logic [3:0] ST_WRD  = 4'd6;
  localparam logic [3:0] ST_WDAT = 4'd7;
  localparam logic [3:0] ST_WCH  = 4'd8;

  logic [3:0] st, st_next;
  cmd_t       cur;
  logic [4:0] pend, pend_next;   // letters still due: bit0 T .. bit3 I, bit4 F
  logic [4:0] idx, idx_next;
  logic [4:0] low_bit, rest;
  logic [7:0] letter;
  logic       gen_valid, adv, last_byte;
  result_t    gen;

  result_t    oq [2];
  logic       owp, orp;
  logic [1:0] ocount;
  logic       ospace, opop;

  assign low_bit   = pend & (~pend + 5'd1);
  assign rest      = pend & (pend - 5'd1);
  assign last_byte = (idx == 5'(PAGE_BYTES - 1));

  always_comb begin
    priority if (low_bit[0]) letter = CHR_T;
    else if (low_bit[1]) letter = CHR_B;
    else if (low_bit[2]) letter = CHR_R;
    else if (low_bit[3]) letter = CHR_I;
    else letter = CHR_F;
  end

  assign ospace = (ocount != 2'd2);
  assign adv    = gen_valid & ospace;
  assign q_pop  = (st == ST_IDLE) && !q_empty;

  always_comb begin
    gen       = '{kind: KIND_TEXT, data: 8'h00, page: 4'd0, idx: 5'd0,
                  flags: cur.flags, last: 1'b0};
    gen_valid = 1'b0;
    st_next   = st;
    pend_next = pend;
    idx_next  = idx;
    req.idx          = idx;
    req.release_line = 1'b0;
    unique case (st)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (head.cmd)
            CMD_LOAD:  st_next = ST_LOAD;
            CMD_WRITE: st_next = ST_WRD;
            default:   st_next = ST_S;
          endcase
          pend_next = {head.flash, head.flags};
          idx_next  = 5'd0;
        end
      end
      ST_LOAD: begin
        gen_valid = 1'b1;
        gen.kind  = KIND_LOAD;
        if (adv) st_next = ST_S;
      end
      ST_S: begin
        gen_valid = 1'b1;
        gen.data  = CHR_S;
        if (adv) st_next = (pend != 5'd0) ? ST_LET : ST_CR;
      end
      ST_LET: begin
        gen_valid = 1'b1;
        gen.data  = letter;
        if (adv) begin
          pend_next = rest;
          if (rest == 5'd0) st_next = ST_CR;
        end
      end
      ST_CR: begin
        gen_valid = 1'b1;
        gen.data  = CHR_CR;
        if (adv) st_next = ST_LF;
      end
      ST_LF: begin
        gen_valid = 1'b1;
        gen.data  = CHR_LF;
        gen.last  = 1'b1;
        if (adv) st_next = ST_IDLE;
      end
      ST_WRD: begin
        st_next = ST_WDAT;   // read data lands in the cycle after the address
      end
      ST_WDAT: begin
        gen_valid = 1'b1;
        gen.kind  = KIND_PAGE;
        gen.data  = {hex_digit(rd_hi), hex_digit(rd_lo)};
        gen.page  = cur.page;
        gen.idx   = idx;
        if (adv) begin
          if (last_byte) begin
            req.release_line = 1'b1;
            st_next = ST_WCH;
          end else begin
            idx_next = idx + 5'd1;
            st_next  = ST_WRD;
          end
        end
      end
      ST_WCH: begin
        gen_valid = 1'b1;
        gen.data  = CHR_W;
        if (adv) st_next = ST_CR;
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    idx  <= idx_next;
    if (q_pop) cur <= head;
  end

  // two-entry result queue so the sequencer keeps going while a result waits
  assign empty = (ocount == 2'd0);
  assign opop  = pop & ~empty;
  assign res   = oq[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= 1'b0;
      orp    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (adv) owp <= ~owp;
      if (opop) orp <= ~orp;
      ocount <= ocount + 2'(adv) - 2'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) oq[owp] <= gen;
  end

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    (adv && gen.last) |-> (gen.kind == KIND_TEXT && gen.data == CHR_LF))
    else $error("last marks a result other than the closing LF");

  a_write_starts_read: assert property (@(posedge clk) disable iff (rst)
    (q_pop && head.cmd == CMD_WRITE) |=> (st == ST_WRD))
    else $error("page command did not start with a store read");

  a_data_after_read: assert property (@(posedge clk) disable iff (rst)
    (st == ST_WDAT) |-> ($past(st) == ST_WRD || $past(st) == ST_WDAT))
    else $error("page byte taken without a prior store read");

  a_ocount_bound: assert property (@(posedge clk) disable iff (rst)
    ocount != 2'd3)
    else $error("result queue overflow");

endmodule

>>> rtl/serial_line_command_parser.sv
`timescale 1ns / 1ps
// channel   handshake          payload
// input     push / full        key[7:0], flash_indicator
// results   empty / pop        out_kind[1:0], out_byte[7:0], page_number[3:0],
//                              byte_index[4:0], light_flags[3:0], last
//
// A byte is taken in any cycle with push high and full low; line bytes go into the
// line store as they are taken. The executor emits one result per cycle while the
// result queue has room; each page byte waits for its line store read first.
// full rises while the command queue is full or a page line is still being read.
// Synchronous reset clears modes, lengths, lights and queues; no clearing pass.
// A stalled result side stops the executor only; the front runs until the queue fills.
module serial_line_command_parser #(
  parameter int LINE_CAPACITY = slcp_pkg::LineCapacityDef,
  parameter int PAGE_BYTES    = slcp_pkg::PageBytesDef,
  parameter int PAGE_COUNT    = slcp_pkg::PageCountDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] key,
  input  logic       flash_indicator,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [3:0] page_number,
  output logic [4:0] byte_index,
  output logic [3:0] light_flags,
  output logic       last
);
  import slcp_pkg::*;

  logic     q_push, q_full, q_pop, q_empty;
  cmd_t     q_wdata, q_rdata;
  mem_req_t req;
  logic [7:0] rd_hi, rd_lo;
  result_t  res;

  slcp_front #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .PAGE_BYTES   (PAGE_BYTES),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_front (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .key(key), .flash_indicator(flash_indicator),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full),
    .req(req), .rd_hi(rd_hi), .rd_lo(rd_lo)
  );

  slcp_cmd_queue u_queue (
    .clk(clk), .rst(rst),
    .wr(q_push), .wr_data(q_wdata), .q_full(q_full),
    .rd(q_pop), .rd_data(q_rdata), .q_empty(q_empty)
  );

  slcp_back #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk(clk), .rst(rst),
    .head(q_rdata), .q_empty(q_empty), .q_pop(q_pop),
    .req(req), .rd_hi(rd_hi), .rd_lo(rd_lo),
    .pop(pop), .empty(empty), .res(res)
  );

  assign out_kind    = res.kind;
  assign out_byte    = res.data;
  assign page_number = res.page;
  assign byte_index  = res.idx;
  assign light_flags = res.flags;
  assign last        = res.last;

endmodule

>>> tb/tb_serial_line_command_parser.sv
`timescale 1ns / 1ps
module tb_serial_line_command_parser;
  import slcp_pkg::*;

  localparam int LINE_CAP  = LineCapacityDef;
  localparam int PAGE_LEN  = PageBytesDef;
  localparam int PAGE_MAX  = PageCountDef;
  localparam int HOLD_LONG = 400;

  typedef enum logic [1:0] {
    MODE_LINE   = 2'd0,
    MODE_GOT_CR = 2'd1,
    MODE_WAIT_LF = 2'd2
  } parse_mode_e;

  typedef enum int {
    LN_STATUS, LN_LOAD, LN_TOGGLE, LN_PAGE, LN_PAGE_BAD,
    LN_NOISE, LN_BROKEN_CR, LN_OVERLONG, LN_RAW
  } line_kind_e;

  // one row of the directed part; reply holds up to six text characters, right aligned
  typedef struct packed {
    logic [7:0]  key;
    logic        flash;
    logic        typed;
    logic [2:0]  nrep;
    logic [47:0] reply;
    logic [3:0]  flags;
  } row_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] key;
  logic       flash_indicator;
  logic       empty;
  logic       pop;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [3:0] page_number;
  logic [4:0] byte_index;
  logic [3:0] light_flags;
  logic       last;

  serial_line_command_parser dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .key             (key),
    .flash_indicator (flash_indicator),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .page_number     (page_number),
    .byte_index      (byte_index),
    .light_flags     (light_flags),
    .last            (last)
  );

  // predictor state
  parse_mode_e pmode;
  int          line_len;
  logic [7:0]  line_buf [LINE_CAP];
  logic [3:0]  lights;

  result_t pending_results [$];
  result_t step_results [$];

  int mismatches;
  int results_seen;
  int useful_items;
  int stall_left;
  bit hold_req;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_at(input int pos);
    return {nibble(line_buf[pos]), nibble(line_buf[pos + 1])};
  endfunction

  task automatic add_result(input logic [1:0] kind, input logic [7:0] b,
                            input logic [3:0] pg, input logic [4:0] ix);
    result_t r;
    r.kind  = kind;
    r.data  = b;
    r.page  = pg;
    r.idx   = ix;
    r.flags = lights;
    r.last  = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic add_status(input logic f);
    add_result(KIND_TEXT, CHR_S, 4'd0, 5'd0);
    if (lights[0]) add_result(KIND_TEXT, CHR_T, 4'd0, 5'd0);
    if (lights[1]) add_result(KIND_TEXT, CHR_B, 4'd0, 5'd0);
    if (lights[2]) add_result(KIND_TEXT, CHR_R, 4'd0, 5'd0);
    if (lights[3]) add_result(KIND_TEXT, CHR_I, 4'd0, 5'd0);
    if (f) add_result(KIND_TEXT, CHR_F, 4'd0, 5'd0);
    add_result(KIND_TEXT, CHR_CR, 4'd0, 5'd0);
    add_result(KIND_TEXT, CHR_LF, 4'd0, 5'd0);
  endtask

  task automatic run_command(input logic f);
    logic [3:0] sel;
    logic [7:0] pg;
    sel = 4'd0;
    if (line_len == 1 && line_buf[0] == CHR_H) begin
      add_status(f);
    end else if (line_len == 2 && line_buf[0] == CHR_T) begin
      case (line_buf[1])
        CHR_T: sel = 4'b0001;
        CHR_B: sel = 4'b0010;
        CHR_R: sel = 4'b0100;
        CHR_I: sel = 4'b1000;
        default: sel = 4'd0;
      endcase
      if (sel != 4'd0) begin
        lights ^= sel;
        add_status(f);
      end
    end else if (line_len == 4 + 2 * PAGE_LEN && line_buf[0] == CHR_W
                 && line_buf[3] == CHR_COLON) begin
      pg = hex_at(1);
      if (pg < PAGE_MAX) begin
        for (int i = 0; i < PAGE_LEN; i++)
          add_result(KIND_PAGE, hex_at(4 + 2 * i), pg[3:0], i[4:0]);
        add_result(KIND_TEXT, CHR_W, 4'd0, 5'd0);
        add_result(KIND_TEXT, CHR_CR, 4'd0, 5'd0);
        add_result(KIND_TEXT, CHR_LF, 4'd0, 5'd0);
      end
    end else if (line_len == 1 && line_buf[0] == CHR_L) begin
      add_result(KIND_LOAD, 8'd0, 4'd0, 5'd0);
      add_status(f);
    end
  endtask

  // works out the results of one item into step_results, last marked
  task automatic predict_replies(input logic [7:0] k, input logic f);
    result_t tail;
    step_results.delete();
    case (pmode)
      MODE_LINE: begin
        if (k == CHR_CR) begin
          pmode = MODE_GOT_CR;
        end else if (k == CHR_LF) begin
          run_command(f);
          line_len = 0;
        end else begin
          if (line_len < LINE_CAP) line_buf[line_len] = k;
          line_len++;
          if (line_len >= LINE_CAP) pmode = MODE_WAIT_LF;
        end
      end
      MODE_GOT_CR: begin
        if (k == CHR_LF) begin
          run_command(f);
          line_len = 0;
          pmode = MODE_LINE;
        end else begin
          pmode = MODE_WAIT_LF;
        end
      end
      default: begin
        if (k == CHR_LF) begin
          line_len = 0;
          pmode = MODE_LINE;
        end
      end
    endcase
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
  endtask

  task automatic offer(input logic [7:0] k, input logic f, input bit use_pred);
    int gap;
    push <= 1'b1;
    key <= k;
    flash_indicator <= f;
    do @(posedge clk); while (full);
    if (pmode == MODE_LINE || pmode == MODE_GOT_CR) useful_items++;
    predict_replies(k, f);
    if (use_pred) foreach (step_results[i]) pending_results.push_back(step_results[i]);
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return "0" + n;
    return (lower ? "a" : "A") + (n - 4'd10);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h7e, 8'h20));
  endfunction

  task automatic send_line(input line_kind_e kind);
    logic [7:0] seq [$];
    logic [7:0] pg;
    logic [7:0] b;
    int n;
    case (kind)
      LN_STATUS: seq.push_back(CHR_H);
      LN_LOAD: seq.push_back(CHR_L);
      LN_TOGGLE: begin
        seq.push_back(CHR_T);
        case ($urandom_range(4))
          0: seq.push_back(CHR_T);
          1: seq.push_back(CHR_B);
          2: seq.push_back(CHR_R);
          3: seq.push_back(CHR_I);
          default: seq.push_back(8'($urandom_range(255)));
        endcase
      end
      LN_PAGE, LN_PAGE_BAD: begin
        seq.push_back(CHR_W);
        if (kind == LN_PAGE) pg = 8'($urandom_range(PAGE_MAX - 1));
        else pg = 8'($urandom_range(255, PAGE_MAX));
        seq.push_back(hex_char(pg[7:4], 1'($urandom_range(1))));
        seq.push_back(hex_char(pg[3:0], 1'($urandom_range(1))));
        seq.push_back(CHR_COLON);
        for (int i = 0; i < 2 * PAGE_LEN; i++) begin
          // now and then a random printable character, which need not be a hex digit
          if ($urandom_range(19) == 0) b = printable();
          else b = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
          seq.push_back(b);
        end
      end
      LN_NOISE: begin
        n = $urandom_range(6, 1);
        repeat (n) seq.push_back(8'($urandom_range(255)));
      end
      LN_BROKEN_CR: begin
        seq.push_back($urandom_range(1) ? CHR_H : CHR_T);
        seq.push_back(CHR_CR);
        do b = 8'($urandom_range(255)); while (b == CHR_LF);
        seq.push_back(b);
        n = $urandom_range(3);
        repeat (n) seq.push_back(8'($urandom_range(255)));
      end
      LN_OVERLONG: begin
        n = $urandom_range(LINE_CAP + 6, LINE_CAP);
        repeat (n) seq.push_back(printable());
      end
      default: seq.push_back(8'($urandom_range(255)));
    endcase
    if (kind != LN_RAW) begin
      if (kind != LN_BROKEN_CR && kind != LN_OVERLONG && $urandom_range(1))
        seq.push_back(CHR_CR);
      seq.push_back(CHR_LF);
    end
    foreach (seq[i]) offer(seq[i], 1'($urandom_range(1)), 1'b1);
  endtask

  function automatic row_t row(input logic [7:0] k, input logic f, input logic typed,
                               input int nrep, input logic [47:0] reply,
                               input logic [3:0] flags);
    row_t r;
    r.key   = k;
    r.flash = f;
    r.typed = typed;
    r.nrep  = nrep[2:0];
    r.reply = reply;
    r.flags = flags;
    return r;
  endfunction

  // receiver: random gaps after accepted items, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_LONG;
      end else if (stall_left == 0 && pop && !empty) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d byte %02h", out_kind, out_byte));
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", out_kind, want.kind);
        check_field("out_byte", out_byte, want.data);
        check_field("page_number", page_number, want.page);
        check_field("byte_index", byte_index, want.idx);
        check_field("light_flags", light_flags, want.flags);
        check_field("last", last, want.last);
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    row_t dir_rows [24];
    row_t rw;
    result_t r;
    line_kind_e forced [3];
    bit drained;
    int pick;

    rst = 1'b1;
    push = 1'b0;
    key = 8'd0;
    flash_indicator = 1'b0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    mismatches = 0;
    results_seen = 0;
    useful_items = 0;
    drained = 1'b0;
    pmode = MODE_LINE;
    line_len = 0;
    lights = 4'd0;

    dir_rows = '{
      row(CHR_H,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 0, 1, 3, {CHR_S, CHR_CR, CHR_LF}, 4'd0),
      row(CHR_T,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_T,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_CR, 0, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 0, 1, 4, {CHR_S, CHR_T, CHR_CR, CHR_LF}, 4'd1),
      row(CHR_T,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_I,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 1, 1, 6, {CHR_S, CHR_T, CHR_I, CHR_F, CHR_CR, CHR_LF}, 4'd9),
      row(CHR_L,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 0, 0, 0, 48'd0, 4'd0),
      // toggle with an unknown letter: dropped
      row(CHR_T,  0, 0, 0, 48'd0, 4'd0),
      row("X",    0, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 0, 1, 0, 48'd0, 4'd0),
      // CR then a stray byte: the line is thrown away at the next LF
      row(CHR_H,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_CR, 0, 0, 0, 48'd0, 4'd0),
      row(8'hff,  1, 0, 0, 48'd0, 4'd0),
      row(8'h00,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 0, 1, 0, 48'd0, 4'd0),
      row(CHR_H,  1, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 1, 1, 6, {CHR_S, CHR_T, CHR_I, CHR_F, CHR_CR, CHR_LF}, 4'd9),
      row(8'h00,  0, 0, 0, 48'd0, 4'd0),
      row(CHR_LF, 0, 1, 0, 48'd0, 4'd0),
      row(CHR_LF, 1, 1, 0, 48'd0, 4'd0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      if (rw.typed) begin
        for (int j = 0; j < rw.nrep; j++) begin
          r.kind  = KIND_TEXT;
          r.data  = rw.reply[8 * (rw.nrep - 1 - j) +: 8];
          r.page  = 4'd0;
          r.idx   = 5'd0;
          r.flags = rw.flags;
          r.last  = (j == rw.nrep - 1);
          pending_results.push_back(r);
        end
      end
      offer(rw.key, rw.flash, !rw.typed);
    end

    // the receiver holds off while the sender keeps offering, so the input stalls
    hold_req = 1'b1;
    forced = '{LN_PAGE, LN_PAGE_BAD, LN_OVERLONG};
    foreach (forced[i]) send_line(forced[i]);

    while (useful_items < 190) begin
      no_idle = (useful_items >= 160 && useful_items < 175);
      if (!drained && useful_items >= 175) begin
        push <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 15) send_line(LN_STATUS);
      else if (pick < 25) send_line(LN_LOAD);
      else if (pick < 50) send_line(LN_TOGGLE);
      else if (pick < 56) send_line(LN_PAGE);
      else if (pick < 58) send_line(LN_PAGE_BAD);
      else if (pick < 72) send_line(LN_NOISE);
      else if (pick < 82) send_line(LN_BROKEN_CR);
      else if (pick < 84) send_line(LN_OVERLONG);
      else send_line(LN_RAW);
    end
    no_idle = 1'b0;
    push <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
